// File: src/normalized_rgb_convolution_macros.svh
// ============================================================================
// normalized_rgb_convolution_macros
// Assertion macros shared by the checker of the convolution block.
// ============================================================================
`ifndef NORMALIZED_RGB_CONVOLUTION_MACROS_SVH
`define NORMALIZED_RGB_CONVOLUTION_MACROS_SVH

// cause seen at one edge, effect required at the next edge
`define NRC_ASSERT_NEXT(label, clk, rst_n, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("nrc checker: next-cycle property failed");

// effect required at the same edge
`define NRC_ASSERT_SAME(label, clk, rst_n, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
        else $error("nrc checker: same-cycle property failed");

// effect required at the edge after reset is applied
`define NRC_ASSERT_RESET(label, clk, rst_n, effect) \
    label: assert property (@(posedge clk) (!rst_n) |=> (effect)) \
        else $error("nrc checker: reset property failed");

`endif

// File: src/nrc_pkg.sv
// ============================================================================
// nrc_pkg
// Types, register codes and the kernel tap lookup of the convolution block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package nrc_pkg;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_K_TOP  = 3'd2;
    localparam logic [2:0] REG_K_MID  = 3'd3;
    localparam logic [2:0] REG_K_BOT  = 3'd4;

    localparam logic [10:0] RST_WIDTH  = 11'd640;
    localparam logic [12:0] RST_HEIGHT = 13'd480;
    localparam logic [23:0] RST_KROW   = 24'h010101;

    localparam logic [12:0] MAX_HEIGHT = 13'd4096;
    localparam logic [7:0]  CHAN_MAX   = 8'd255;
    localparam logic [3:0]  LAST_TAP   = 4'd8;
    localparam logic [4:0]  LAST_DIV   = 5'd19;

    typedef struct packed {
        logic       req_type;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_word;

    typedef struct packed {
        logic [9:0]  out_column;
        logic [11:0] out_row;
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic        frame_end;
    } t_out_word;

    typedef struct packed {
        logic [10:0] width;
        logic [12:0] height;
        logic [23:0] k_top;
        logic [23:0] k_mid;
        logic [23:0] k_bot;
    } t_cfg;

    typedef struct packed {
        logic [8:0][23:0] pix;
        logic [8:0]       tap_en;
        logic [9:0]       out_column;
        logic [11:0]      out_row;
        logic             frame_end;
    } t_job;

    function automatic logic signed [7:0] tap_weight(input t_cfg cfg, input logic [3:0] tap);
        logic [7:0] b;
        begin
            case (tap)
                4'd0: b = cfg.k_top[7:0];
                4'd1: b = cfg.k_top[15:8];
                4'd2: b = cfg.k_top[23:16];
                4'd3: b = cfg.k_mid[7:0];
                4'd4: b = cfg.k_mid[15:8];
                4'd5: b = cfg.k_mid[23:16];
                4'd6: b = cfg.k_bot[7:0];
                4'd7: b = cfg.k_bot[15:8];
                4'd8: b = cfg.k_bot[23:16];
                default: b = 8'd0;
            endcase
            tap_weight = $signed(b);
        end
    endfunction

endpackage

`default_nettype wire

// File: src/nrc_front.sv
// ============================================================================
// nrc_front
// Takes words, keeps the line stores and the window, emits one job per output.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module nrc_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  nrc_pkg::t_cfg     i_cfg,
    input  wire               i_push,
    output logic              o_full,
    input  nrc_pkg::t_in_word i_data,
    output logic              o_job_push,
    output nrc_pkg::t_job     o_job,
    input  wire               i_job_full
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > 11) ? CW + 1 : 11;
    localparam int FW = CW + 1;

    typedef enum logic {S_IDLE, S_PROC} t_state;

    t_state            r_state;
    nrc_pkg::t_in_word r_item;
    logic [CW-1:0]     r_col, n_col, r_ocol, n_ocol;
    logic [11:0]       r_row, n_row, r_orow, n_orow;
    logic [FW-1:0]     r_fill, n_fill, r_owed, n_owed;
    logic [8:0][23:0]  r_win, n_win;
    logic [23:0]       r_rd_up, r_rd_lo;
    logic [23:0]       mem_up [MAX_WIDTH];
    logic [23:0]       mem_lo [MAX_WIDTH];

    logic [WW-1:0] w;
    logic [12:0]   h;
    logic          drain, skip, primed, go, do_shift;
    logic [23:0]   px;
    logic          top_ok, bot_ok, left_ok, right_ok;
    logic [FW-1:0] owed_inc;
    logic [8:0]    tap_en;

    always_comb begin
        if (i_cfg.width == 11'd0) begin
            w = WW'(1);
        end else if (WW'(i_cfg.width) > WW'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(i_cfg.width);
        end
        if (i_cfg.height == 13'd0) begin
            h = 13'd1;
        end else if (i_cfg.height > nrc_pkg::MAX_HEIGHT) begin
            h = nrc_pkg::MAX_HEIGHT;
        end else begin
            h = i_cfg.height;
        end

        drain    = (r_item.req_type == nrc_pkg::REQ_DRAIN);
        skip     = drain && (r_owed == '0);
        px       = drain ? 24'd0 : {r_item.blue_in, r_item.green_in, r_item.red_in};
        primed   = (WW + 1)'(r_fill) >= ((WW + 1)'(w) + (WW + 1)'(1));
        go       = (r_state == S_PROC) && (skip || !primed || !i_job_full);
        do_shift = go && !skip;

        for (int y = 0; y < 3; y++) begin
            n_win[y*3]     = r_win[y*3+1];
            n_win[y*3 + 1] = r_win[y*3+2];
        end
        n_win[2] = r_rd_up;
        n_win[5] = r_rd_lo;
        n_win[8] = px;

        top_ok   = (r_orow != 12'd0);
        bot_ok   = (13'(r_orow) + 13'd1) < h;
        left_ok  = (r_ocol != '0);
        right_ok = (WW'(r_ocol) + WW'(1)) < w;
        for (int y = 0; y < 3; y++) begin
            tap_en[y*3]     = left_ok  && (y == 1 || (y == 0 ? top_ok : bot_ok));
            tap_en[y*3 + 1] =             (y == 1 || (y == 0 ? top_ok : bot_ok));
            tap_en[y*3 + 2] = right_ok && (y == 1 || (y == 0 ? top_ok : bot_ok));
        end

        if ((WW'(r_col) + WW'(1)) >= w) begin
            n_col = '0;
            n_row = ((13'(r_row) + 13'd1) >= h) ? 12'd0 : r_row + 12'd1;
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
        if (right_ok) begin
            n_ocol = r_ocol + CW'(1);
            n_orow = r_orow;
        end else begin
            n_ocol = '0;
            n_orow = bot_ok ? r_orow + 12'd1 : 12'd0;
        end
        if (!primed) begin
            n_ocol = r_ocol;
            n_orow = r_orow;
        end

        owed_inc = r_owed + (drain ? FW'(0) : FW'(1));
        n_owed   = (primed && owed_inc != '0) ? owed_inc - FW'(1) : owed_inc;
        n_fill   = primed ? r_fill : r_fill + FW'(1);
    end

    assign o_full     = (r_state != S_IDLE);
    assign o_job_push = do_shift && primed;

    always_comb begin
        o_job.pix        = n_win;
        o_job.tap_en     = tap_en;
        o_job.out_column = 10'(r_ocol);
        o_job.out_row    = r_orow;
        o_job.frame_end  = !right_ok && !bot_ok;
    end

    always_ff @(posedge i_clk) begin
        r_rd_up <= mem_up[r_col];
        r_rd_lo <= mem_lo[r_col];
        if (do_shift) begin
            mem_up[r_col] <= r_rd_lo;
            mem_lo[r_col] <= px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= 12'd0;
            r_ocol  <= '0;
            r_orow  <= 12'd0;
            r_fill  <= '0;
            r_owed  <= '0;
            r_win   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_push) begin
                        r_item  <= i_data;
                        r_state <= S_PROC;
                    end
                end
                S_PROC: begin
                    if (go) begin
                        r_state <= S_IDLE;
                    end
                    if (do_shift) begin
                        r_win <= n_win;
                        if (drain && n_owed == '0) begin
                            r_col  <= '0;
                            r_row  <= 12'd0;
                            r_ocol <= '0;
                            r_orow <= 12'd0;
                            r_fill <= '0;
                        end else begin
                            r_col  <= n_col;
                            r_row  <= n_row;
                            r_ocol <= n_ocol;
                            r_orow <= n_orow;
                            r_fill <= n_fill;
                        end
                        r_owed <= n_owed;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/nrc_queue.sv
// ============================================================================
// nrc_queue
// Two-entry job queue between the front and the back.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module nrc_queue (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push,
    input  nrc_pkg::t_job i_job,
    output logic          o_full,
    input  wire           i_pop,
    output nrc_pkg::t_job o_job,
    output logic          o_empty
);

    nrc_pkg::t_job r_slot [2];
    logic          r_wr, r_rd;
    logic [1:0]    r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= !r_wr;
            end
            if (do_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

`default_nettype wire

// File: src/nrc_back.sv
// ============================================================================
// nrc_back
// Weighted tap sum, restoring divide by the weight sum, clamp, result word.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module nrc_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  nrc_pkg::t_cfg      i_cfg,
    input  nrc_pkg::t_job      i_job,
    input  wire                i_job_empty,
    output logic               o_job_pop,
    output nrc_pkg::t_out_word o_data,
    output logic               o_empty,
    input  wire                i_pop
);

    typedef enum logic [2:0] {B_IDLE, B_MAC, B_PREP, B_DIV, B_HOLD} t_state;

    t_state             r_state;
    nrc_pkg::t_job      r_job;
    logic [3:0]         r_tap;
    logic signed [20:0] r_acc [3];
    logic signed [11:0] r_mass;
    logic [10:0]        r_dvs;
    logic [10:0]        r_rem [3];
    logic [19:0]        r_quo [3];
    logic               r_neg [3];
    logic [4:0]         r_cnt;
    nrc_pkg::t_out_word r_out;
    logic               r_out_valid;

    logic signed [7:0]  wt;
    logic [23:0]        p;
    logic signed [16:0] prod [3];
    logic [20:0]        acc_abs [3];
    logic [11:0]        mass_abs;
    logic [11:0]        trial [3];
    logic [7:0]         chan [3];
    logic               out_load;

    always_comb begin
        wt       = nrc_pkg::tap_weight(i_cfg, r_tap);
        p        = r_job.pix[r_tap];
        mass_abs = r_mass[11] ? 12'(-r_mass) : 12'(r_mass);
        for (int c = 0; c < 3; c++) begin
            prod[c]    = wt * $signed({1'b0, p[8*c +: 8]});
            acc_abs[c] = r_acc[c][20] ? 21'(-r_acc[c]) : 21'(r_acc[c]);
            trial[c]   = {r_rem[c], r_quo[c][19]};
            if (r_neg[c]) begin
                chan[c] = 8'd0;
            end else if (r_quo[c][19:8] != 12'd0) begin
                chan[c] = nrc_pkg::CHAN_MAX;
            end else begin
                chan[c] = r_quo[c][7:0];
            end
        end
    end

    assign out_load  = (r_state == B_HOLD) && (!r_out_valid || i_pop);
    assign o_job_pop = (r_state == B_IDLE) && !i_job_empty;
    assign o_data    = r_out;
    assign o_empty   = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_job_empty) begin
                        r_job  <= i_job;
                        r_tap  <= 4'd0;
                        r_mass <= 12'sd0;
                        for (int c = 0; c < 3; c++) begin
                            r_acc[c] <= 21'sd0;
                        end
                        r_state <= B_MAC;
                    end
                end
                B_MAC: begin
                    if (r_job.tap_en[r_tap]) begin
                        r_mass <= r_mass + {{4{wt[7]}}, wt};
                        for (int c = 0; c < 3; c++) begin
                            r_acc[c] <= r_acc[c] + {{4{prod[c][16]}}, prod[c]};
                        end
                    end
                    r_tap <= r_tap + 4'd1;
                    if (r_tap == nrc_pkg::LAST_TAP) begin
                        r_state <= B_PREP;
                    end
                end
                B_PREP: begin
                    r_dvs <= (r_mass == 12'sd0) ? 11'd1 : mass_abs[10:0];
                    r_cnt <= 5'd0;
                    for (int c = 0; c < 3; c++) begin
                        r_rem[c] <= 11'd0;
                        r_quo[c] <= acc_abs[c][19:0];
                        r_neg[c] <= r_acc[c][20] ^ r_mass[11];
                    end
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    for (int c = 0; c < 3; c++) begin
                        if (trial[c] >= {1'b0, r_dvs}) begin
                            r_rem[c] <= 11'(trial[c] - {1'b0, r_dvs});
                            r_quo[c] <= {r_quo[c][18:0], 1'b1};
                        end else begin
                            r_rem[c] <= trial[c][10:0];
                            r_quo[c] <= {r_quo[c][18:0], 1'b0};
                        end
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == nrc_pkg::LAST_DIV) begin
                        r_state <= B_HOLD;
                    end
                end
                B_HOLD: begin
                    if (out_load) begin
                        r_out.out_column <= r_job.out_column;
                        r_out.out_row    <= r_job.out_row;
                        r_out.red_out    <= chan[0];
                        r_out.green_out  <= chan[1];
                        r_out.blue_out   <= chan[2];
                        r_out.frame_end  <= r_job.frame_end;
                        r_state          <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/normalized_rgb_convolution.sv
// ============================================================================
// normalized_rgb_convolution
// Normalized 3x3 RGB convolution over a raster stream, queue-style ports.
// ============================================================================
//  channel   handshake          payload          direction
//  input     push / full        i_data           in
//  result    empty / pop        o_data           out
//  config    psel/penable/...   pwdata/prdata    APB
//
//  Front: one word at a time, idle then process state; a full job queue can hold
//  it (line store read is registered). Back: job load, nine-tap loop, divider
//  setup, 20-bit restoring divider, output hold; a 2-deep job queue sits between.
//  The back sets the sustained rate for pixel words that give a result.
//  Reset is synchronous; line stores are not cleared.
//  full stays high while the front is busy, also while a full job queue holds it.
`timescale 1ns / 1ps
`default_nettype none

module normalized_rgb_convolution #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                push,
    output logic               full,
    input  nrc_pkg::t_in_word  i_data,
    output logic               empty,
    input  wire                pop,
    output nrc_pkg::t_out_word o_data,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [4:0]         paddr,
    input  wire  [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    nrc_pkg::t_cfg r_cfg;
    logic [2:0]    reg_idx;
    logic          q_push, q_full, q_pop, q_empty;
    nrc_pkg::t_job f_job, q_job;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= nrc_pkg::RST_WIDTH;
            r_cfg.height <= nrc_pkg::RST_HEIGHT;
            r_cfg.k_top  <= nrc_pkg::RST_KROW;
            r_cfg.k_mid  <= nrc_pkg::RST_KROW;
            r_cfg.k_bot  <= nrc_pkg::RST_KROW;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                nrc_pkg::REG_WIDTH:  r_cfg.width  <= pwdata[10:0];
                nrc_pkg::REG_HEIGHT: r_cfg.height <= pwdata[12:0];
                nrc_pkg::REG_K_TOP:  r_cfg.k_top  <= pwdata[23:0];
                nrc_pkg::REG_K_MID:  r_cfg.k_mid  <= pwdata[23:0];
                nrc_pkg::REG_K_BOT:  r_cfg.k_bot  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            nrc_pkg::REG_WIDTH:  prdata = {21'd0, r_cfg.width};
            nrc_pkg::REG_HEIGHT: prdata = {19'd0, r_cfg.height};
            nrc_pkg::REG_K_TOP:  prdata = {8'd0, r_cfg.k_top};
            nrc_pkg::REG_K_MID:  prdata = {8'd0, r_cfg.k_mid};
            nrc_pkg::REG_K_BOT:  prdata = {8'd0, r_cfg.k_bot};
            default:             prdata = 32'd0;
        endcase
    end

    nrc_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (push),
        .o_full     (full),
        .i_data     (i_data),
        .o_job_push (q_push),
        .o_job      (f_job),
        .i_job_full (q_full)
    );

    nrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_empty (q_empty)
    );

    nrc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (q_job),
        .i_job_empty (q_empty),
        .o_job_pop   (q_pop),
        .o_data      (o_data),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

`default_nettype wire

// File: src/nrc_checker.sv
// ============================================================================
// nrc_checker
// Port-level checks of the convolution block, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "normalized_rgb_convolution_macros.svh"

module nrc_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                push,
    input wire                full,
    input wire                empty,
    input wire                pop,
    input nrc_pkg::t_out_word o_data,
    input wire                pready
);

    `NRC_ASSERT_RESET(a_reset_empty, i_clk, i_rst_n, empty && !full)
    `NRC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, push && !full, full)
    `NRC_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_data))
    `NRC_ASSERT_SAME(a_ready_high, i_clk, i_rst_n, 1'b1, pready)

endmodule

bind normalized_rgb_convolution nrc_checker u_nrc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_data  (o_data),
    .pready  (pready)
);

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the normalized 3x3 RGB convolution block. It
// streams frames of raster pixels and drain words into the block. A model of
// the line stores, the window and the masked, normalized sum predicts each
// filtered word, and every popped word is checked against the oldest
// prediction. Frame sizes and kernels are changed over the APB port between
// phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import nrc_pkg::*;

    localparam int MAXW       = 1024;
    localparam int SETTLE     = 120;
    localparam int STALL_MAX  = 6000;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_in_word    i_data;
    logic        empty;
    logic        pop;
    t_out_word   o_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    normalized_rgb_convolution dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_data  (i_data),
        .empty   (empty),
        .pop     (pop),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // model state
    t_cfg        cfg;
    logic [23:0] row_above [MAXW];
    logic [23:0] row_prev  [MAXW];
    logic [23:0] win [3][3];
    int unsigned in_col, in_row, out_col, out_row, fill_cnt, owed_cnt;

    t_out_word   filtered_q[$];
    int          mismatches;
    int          n_words;
    int          idle_cycles;
    bit          steady;

    function automatic int unsigned eff_width();
        if (cfg.width == 0) return 1;
        if (cfg.width > MAXW) return MAXW;
        return cfg.width;
    endfunction

    function automatic int unsigned eff_height();
        if (cfg.height == 0) return 1;
        if (cfg.height > MAX_HEIGHT) return MAX_HEIGHT;
        return cfg.height;
    endfunction

    function automatic void step_pos(ref int unsigned c, ref int unsigned r,
                                     input int unsigned wd, input int unsigned ht);
        if (c + 1 >= wd) begin
            c = 0;
            r = (r + 1 >= ht) ? 0 : r + 1;
        end else begin
            c = c + 1;
        end
    endfunction

    function automatic int kernel_weight(int y, int x);
        logic [23:0] kr;
        kr = (y == 0) ? cfg.k_top : (y == 1) ? cfg.k_mid : cfg.k_bot;
        return int'($signed(kr[8*x +: 8]));
    endfunction

    task automatic convolve_word(input t_in_word w);
        int unsigned wd, ht;
        logic [23:0] px, up, lo;
        bit          drn, primed;
        int          acc [3];
        int          mass, wt, q;
        t_out_word   r;
        wd  = eff_width();
        ht  = eff_height();
        drn = (w.req_type == REQ_DRAIN);
        px  = {w.blue_in, w.green_in, w.red_in};
        if (drn) begin
            if (owed_cnt == 0) return;
            px = '0;
        end
        up = row_above[in_col];
        lo = row_prev[in_col];
        row_above[in_col] = lo;
        row_prev[in_col]  = px;
        for (int y = 0; y < 3; y++) begin
            win[y][0] = win[y][1];
            win[y][1] = win[y][2];
        end
        win[0][2] = up;
        win[1][2] = lo;
        win[2][2] = px;
        step_pos(in_col, in_row, wd, ht);
        if (!drn) owed_cnt++;
        primed = (fill_cnt >= wd + 1);
        if (!primed) fill_cnt++;
        if (primed) begin
            acc  = '{0, 0, 0};
            mass = 0;
            for (int y = 0; y < 3; y++) begin
                if (y == 0 && out_row == 0) continue;
                if (y == 2 && out_row + 1 >= ht) continue;
                for (int x = 0; x < 3; x++) begin
                    if (x == 0 && out_col == 0) continue;
                    if (x == 2 && out_col + 1 >= wd) continue;
                    wt = kernel_weight(y, x);
                    for (int ch = 0; ch < 3; ch++)
                        acc[ch] += wt * int'(win[y][x][8*ch +: 8]);
                    mass += wt;
                end
            end
            if (mass == 0) mass = 1;
            r.out_column = out_col[9:0];
            r.out_row    = out_row[11:0];
            q = acc[0] / mass;
            r.red_out   = (q > 255) ? CHAN_MAX : (q < 0) ? 8'd0 : q[7:0];
            q = acc[1] / mass;
            r.green_out = (q > 255) ? CHAN_MAX : (q < 0) ? 8'd0 : q[7:0];
            q = acc[2] / mass;
            r.blue_out  = (q > 255) ? CHAN_MAX : (q < 0) ? 8'd0 : q[7:0];
            r.frame_end = (out_col + 1 >= wd && out_row + 1 >= ht);
            filtered_q.push_back(r);
            step_pos(out_col, out_row, wd, ht);
            if (owed_cnt > 0) owed_cnt--;
        end
        if (drn && owed_cnt == 0) begin
            in_col   = 0;
            in_row   = 0;
            out_col  = 0;
            out_row  = 0;
            fill_cnt = 0;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (filtered_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word col=%0d row=%0d", o_data.out_column,
                             o_data.out_row);
            end else begin
                if (o_data !== filtered_q[0]) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp c%0d r%0d rgb %0d %0d %0d fe%0b",
                                 filtered_q[0].out_column, filtered_q[0].out_row,
                                 filtered_q[0].red_out, filtered_q[0].green_out,
                                 filtered_q[0].blue_out, filtered_q[0].frame_end);
                        $display("         got c%0d r%0d rgb %0d %0d %0d fe%0b",
                                 o_data.out_column, o_data.out_row, o_data.red_out,
                                 o_data.green_out, o_data.blue_out, o_data.frame_end);
                    end
                end
                void'(filtered_q.pop_front());
            end
        end
    end

    // result side stalls
    always @(posedge i_clk) begin
        if (!i_rst_n)
            pop <= 1'b0;
        else
            pop <= steady || ($urandom_range(0, 99) >= 8);
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_word(input t_in_word w);
        if (!steady && $urandom_range(0, 99) < 8) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_data <= w;
        do @(posedge i_clk); while (full);
        convolve_word(w);
        n_words++;
    endtask

    task automatic send_pixel(input logic [23:0] rgb);
        t_in_word w;
        w.req_type = REQ_PIXEL;
        {w.blue_in, w.green_in, w.red_in} = rgb;
        send_word(w);
    endtask

    task automatic send_drain();
        t_in_word w;
        w = $bits(t_in_word)'($urandom);
        w.req_type = REQ_DRAIN;
        send_word(w);
    endtask

    task automatic flush_frame();
        while (owed_cnt > 0) send_drain();
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg.width  = val[10:0];
            REG_HEIGHT: cfg.height = val[12:0];
            REG_K_TOP:  cfg.k_top  = val[23:0];
            REG_K_MID:  cfg.k_mid  = val[23:0];
            REG_K_BOT:  cfg.k_bot  = val[23:0];
            default: ;
        endcase
    endtask

    task automatic set_frame(input logic [31:0] wd, input logic [31:0] ht,
                             input logic [31:0] kt, input logic [31:0] km,
                             input logic [31:0] kb);
        wait_idle();
        write_reg(REG_WIDTH, wd);
        write_reg(REG_HEIGHT, ht);
        write_reg(REG_K_TOP, kt);
        write_reg(REG_K_MID, km);
        write_reg(REG_K_BOT, kb);
    endtask

    function automatic logic [23:0] rand_pixel();
        logic [23:0] p;
        p = 24'($urandom);
        if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
        return p;
    endfunction

    function automatic logic [31:0] rand_kernel();
        case ($urandom_range(0, 7))
            0: return 32'h000000;
            1: return 32'h808080;
            2: return 32'h7F7F7F;
            3: return 32'h01FF01;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_extremes();
        set_frame(3, 3, 32'h7F8001, 32'h01FF7F, 32'h808080);
        for (int i = 0; i < 9; i++) send_pixel(i[0] ? 24'hFFFFFF : 24'h000000);
        flush_frame();
        send_drain();
        set_frame(3, 2, 32'h0, 32'h0, 32'h0);
        for (int i = 0; i < 6; i++) send_pixel(rand_pixel());
        send_drain();
        send_pixel(24'h123456);
        flush_frame();
        set_frame(0, 0, 32'h010101, 32'h010101, 32'h010101);
        send_pixel(24'hA5A5A5);
        flush_frame();
    endtask

    task automatic test_size_limits();
        set_frame(2047, 1, 32'h010203, 32'h7F0405, 32'hFF0201);
        for (int i = 0; i < 3; i++) send_pixel(rand_pixel());
        flush_frame();
        set_frame(2, 8191, $urandom, $urandom, $urandom);
        for (int i = 0; i < 8; i++) send_pixel(rand_pixel());
        flush_frame();
        set_frame(3, 4096, 32'h020202, 32'h010101, 32'h020202);
        for (int i = 0; i < 6; i++) send_pixel(rand_pixel());
        flush_frame();
    endtask

    task automatic test_shrink_midframe();
        set_frame(6, 4, 32'h010101, 32'h020402, 32'h010101);
        for (int i = 0; i < 15; i++) send_pixel(rand_pixel());
        wait_idle();
        write_reg(REG_WIDTH, 3);
        for (int i = 0; i < 7; i++) send_pixel(rand_pixel());
        flush_frame();
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        set_frame(5, 3, rand_kernel(), rand_kernel(), rand_kernel());
        for (int i = 0; i < 45; i++) send_pixel(rand_pixel());
        flush_frame();
        steady = 1'b0;
    endtask

    task automatic test_random_frames();
        int unsigned wd, ht, npx;
        while (n_words < 750) begin
            wd = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            ht = $urandom_range(1, 6);
            if (owed_cnt == 0 || $urandom_range(0, 3) == 0)
                set_frame(wd, ht, rand_kernel(), rand_kernel(), rand_kernel());
            wd  = eff_width();
            ht  = eff_height();
            npx = wd * ht;
            if ($urandom_range(0, 9) == 0) npx = $urandom_range(1, npx);
            for (int i = 0; i < npx; i++) begin
                if ($urandom_range(0, 49) == 0) send_drain();
                send_pixel(rand_pixel());
            end
            if ($urandom_range(0, 4) != 0) begin
                flush_frame();
                if ($urandom_range(0, 3) == 0) send_drain();
            end
        end
        flush_frame();
    endtask

    initial begin
        i_rst_n  = 1'b0;
        push     = 1'b0;
        i_data   = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        steady   = 1'b0;
        mismatches  = 0;
        n_words     = 0;
        idle_cycles = 0;
        cfg = {RST_WIDTH, RST_HEIGHT, RST_KROW, RST_KROW, RST_KROW};
        for (int i = 0; i < MAXW; i++) begin
            row_above[i] = '0;
            row_prev[i]  = '0;
        end
        for (int y = 0; y < 3; y++)
            for (int x = 0; x < 3; x++) win[y][x] = '0;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0; fill_cnt = 0; owed_cnt = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_size_limits();
        test_shrink_midframe();
        test_back_to_back();
        test_random_frames();

        wait_idle();
        if (mismatches == 0 && filtered_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/nrc_pkg.sv
src/nrc_front.sv
src/nrc_queue.sv
src/nrc_back.sv
src/normalized_rgb_convolution.sv
src/nrc_checker.sv
bench/tb_top.sv
